[design/mexp_pkg.sv]
package mexp_pkg;

  localparam int DEFAULT_DATA_WIDTH = 63;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;         // latch operands, result starts at one
    logic acc_clear;    // clear the accumulator
    logic step;         // one shift-add-reduce step of the accumulator
    logic step_reduce;  // step brings in a raw base bit (base mod modulus)
    logic sel_base;     // multiplicand is the base, else the running result
    logic write_r;      // running result takes the step value
    logic write_b;      // base takes the step value
    logic shift_e;      // drop the exponent lsb
    logic out_load;     // capture the final result into the output register
  } mexp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_lsb;
  } mexp_status_t;

endpackage

[design/mexp_in_if.sv]
interface mexp_in_if
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] base_value;
  logic [DATA_WIDTH-1:0] power;
  logic [DATA_WIDTH-1:0] modulus;

  modport source (output valid, output base_value, output power, output modulus, input ready);
  modport sink   (input valid, input base_value, input power, input modulus, output ready);
endinterface

[design/mexp_out_if.sv]
interface mexp_out_if
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] residue;
  logic                  bad_modulus;

  modport source (output valid, output residue, output bad_modulus, input ready);
  modport sink   (input valid, input residue, input bad_modulus, output ready);
endinterface

[design/mexp_datapath.sv]
module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  localparam int IDX_WIDTH = $clog2(DATA_WIDTH)
) (
  input  logic                  clk,
  input  mexp_cmd_t             cmd,
  input  logic [IDX_WIDTH-1:0]  bit_idx,
  input  logic [DATA_WIDTH-1:0] base_value,
  input  logic [DATA_WIDTH-1:0] power,
  input  logic [DATA_WIDTH-1:0] modulus,
  output mexp_status_t          status,
  output logic [DATA_WIDTH-1:0] residue,
  output logic                  bad_modulus
);

  localparam int TW = DATA_WIDTH + 2;

  logic [DATA_WIDTH-1:0] base_q;
  logic [DATA_WIDTH-1:0] expo;
  logic [DATA_WIDTH-1:0] modv;
  logic [DATA_WIDTH-1:0] result;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] acc_next;
  logic [DATA_WIDTH-1:0] operand;
  logic                  sel_bit;
  logic [TW-1:0]         addend;
  logic [TW-1:0]         sum;
  logic [TW-1:0]         mod1;
  logic [TW-1:0]         mod2;
  logic [TW-1:0]         diff1;
  logic [TW-1:0]         diff2;

  assign operand = cmd.sel_base ? base_q : result;
  assign sel_bit = base_q[bit_idx];

  // sum = 2*acc + addend stays below 3*modulus, so at most two subtractions
  always_comb begin
    if (cmd.step_reduce) begin
      addend = TW'(sel_bit);
    end else if (sel_bit) begin
      addend = {2'b00, operand};
    end else begin
      addend = '0;
    end
    sum   = {1'b0, acc, 1'b0} + addend;
    mod1  = {2'b00, modv};
    mod2  = {1'b0, modv, 1'b0};
    diff1 = sum - mod1;
    diff2 = sum - mod2;
    if (sum >= mod2) begin
      acc_next = diff2[DATA_WIDTH-1:0];
    end else if (sum >= mod1) begin
      acc_next = diff1[DATA_WIDTH-1:0];
    end else begin
      acc_next = sum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_q <= base_value;
      expo   <= power;
      modv   <= modulus;
      result <= DATA_WIDTH'(1);
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.step) begin
      acc <= acc_next;
    end
    if (cmd.write_b) begin
      base_q <= acc_next;
    end
    if (cmd.write_r) begin
      result <= acc_next;
    end
    if (cmd.shift_e) begin
      expo <= expo >> 1;
    end
    if (cmd.out_load) begin
      residue     <= status.m_zero ? '0 : result;
      bad_modulus <= status.m_zero;
    end
  end

  assign status.m_zero = (modv == '0);
  assign status.e_zero = (expo == '0);
  assign status.e_lsb  = expo[0];

endmodule

[design/mexp_ctrl.sv]
module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  localparam int IDX_WIDTH = $clog2(DATA_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  mexp_status_t         status,
  output mexp_cmd_t            cmd,
  output logic [IDX_WIDTH-1:0] bit_idx
);

  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    CHECK,
    MUL_R,
    MUL_B,
    DONE
  } state_t;

  state_t               state;
  logic [IDX_WIDTH-1:0] cnt;
  logic                 last;
  logic                 out_free;
  logic                 out_set;

  assign in_ready = (state == IDLE);
  assign bit_idx  = cnt;
  assign last     = (cnt == '0);
  assign out_free = !out_valid || out_ready;
  assign out_set  = (state == DONE) && out_free;

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load      = in_valid;
        cmd.acc_clear = in_valid;
      end
      REDUCE: begin
        cmd.step        = 1'b1;
        cmd.step_reduce = 1'b1;
        cmd.write_b     = last;
      end
      CHECK: begin
        cmd.acc_clear = 1'b1;
      end
      MUL_R: begin
        cmd.step      = 1'b1;
        cmd.write_r   = last;
        cmd.acc_clear = last;
      end
      MUL_B: begin
        cmd.step     = 1'b1;
        cmd.sel_base = 1'b1;
        cmd.write_b  = last;
        cmd.shift_e  = last;
      end
      DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= REDUCE;
            cnt   <= LAST_IDX;
          end
        end
        REDUCE: begin
          if (last) begin
            state <= CHECK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        CHECK: begin
          cnt <= LAST_IDX;
          if (status.m_zero || status.e_zero) begin
            state <= DONE;
          end else if (status.e_lsb) begin
            state <= MUL_R;
          end else begin
            state <= MUL_B;
          end
        end
        MUL_R: begin
          if (last) begin
            state <= MUL_B;
            cnt   <= LAST_IDX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MUL_B: begin
          if (last) begin
            state <= CHECK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[design/modular_exponentiation_unit.sv]
// modular exponentiation unit: residue = base_value ** power mod modulus
// operands channel (sink): base_value, power, modulus, unsigned DATA_WIDTH bits
// result channel (source): residue and bad_modulus, one transaction per operand
// transaction, delivered in order
// operation: the base is first reduced by the modulus with a bit-serial
// restoring remainder, then the exponent is scanned lsb first; each scan
// step passes through a check state, then uses the shared shift-add modular
// multiplier to multiply the result by the base for a set bit and then to
// square the base
// throughput: one transaction at a time; the next operand transaction is taken
// as soon as the result sits in the output register
// zero modulus: bad_modulus high and residue zero after the reduction pass
// zero exponent: residue is one, not reduced
// reset: synchronous, returns the controller to idle and drops result valid
// stall: a result waiting on the output register holds the controller in its
// final state; the operands channel stays closed until the register frees up
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input logic         clk,
  input logic         rst,
  mexp_in_if.sink     operands,
  mexp_out_if.source  result
);

  localparam int IDX_WIDTH = $clog2(DATA_WIDTH);

  mexp_cmd_t            cmd;
  mexp_status_t         status;
  logic [IDX_WIDTH-1:0] bit_idx;

  // sequencer: reduction, square and multiply scan, output handoff
  mexp_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .status    (status),
    .cmd       (cmd),
    .bit_idx   (bit_idx)
  );

  // operand registers, shared modular step unit and output register
  mexp_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .bit_idx     (bit_idx),
    .base_value  (operands.base_value),
    .power       (operands.power),
    .modulus     (operands.modulus),
    .status      (status),
    .residue     (result.residue),
    .bad_modulus (result.bad_modulus)
  );

  // a flagged modulus always comes with a zero residue
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_modulus |-> result.residue == '0)
    else $error("bad modulus with nonzero residue");

  // after an accepted transaction the block is busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("operands accepted twice in a row");

  // result and base are never updated by the same step
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_r && cmd.write_b))
    else $error("result and base written together");

  // output capture only happens into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !result.valid || result.ready)
    else $error("output register overwritten");

endmodule
